// ----- sv/bounded_double_ended_queue_unit_assert.svh -----
// Assertion macros for the bounded double-ended queue unit.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define BDEQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdeq check failed");

// Next-cycle implication, checked outside reset.
`define BDEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdeq check failed");

`else

`define BDEQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BDEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/bdeq_pkg.sv -----
// Shared types and constants for the bounded double-ended queue.
`timescale 1ns / 1ps

package bdeq_pkg;

    localparam int unsigned FIELD_W       = 32;
    localparam int unsigned ENTRY_COUNT_W = 5;
    localparam int unsigned REQ_W         = 3;
    localparam int unsigned STATUS_W      = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_BACK   = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_QUERY      = 3'd4
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture request on input transfer
        logic exec;   // apply request to store and pointers
        logic read;   // read front and back words
    } t_dp_cmd;

endpackage

// ----- sv/bounded_double_ended_queue_unit.sv -----
// Bounded double-ended queue: top level with sequencer, datapath and checks.
// The request is captured on input transfer; the store write in the execute state
// is followed by the registered two-port read of the ring; the result is shown in
// the response state. One request at a time: stalled until the result is taken.
// Reset (i_rst_n, synchronous, active low) empties the queue: head and count cleared.
// The store itself is not cleared; no clearing pass, requests accepted right away.
`timescale 1ns / 1ps
`include "bounded_double_ended_queue_unit_assert.svh"

module bounded_double_ended_queue_unit #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [bdeq_pkg::REQ_W-1:0]          i_req_type,
    input  logic signed [bdeq_pkg::FIELD_W-1:0] i_push_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [bdeq_pkg::FIELD_W-1:0] o_front_value,
    output logic signed [bdeq_pkg::FIELD_W-1:0] o_back_value,
    output logic [bdeq_pkg::ENTRY_COUNT_W-1:0]  o_entry_count,
    output logic                                o_is_empty,
    output logic [bdeq_pkg::STATUS_W-1:0]       o_status
);

    bdeq_pkg::t_dp_cmd cmd;

    bdeq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    bdeq_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_req_type    (i_req_type),
        .i_push_value  (i_push_value),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_status      (o_status)
    );

    // no new transfer while a result is pending
    `BDEQ_ASSERT_IMPL(a_hold_while_resp, i_clk, i_rst_n, o_valid, o_stall)
    // an accepted request produces its result after the execute and read states
    `BDEQ_ASSERT_IMPL(a_resp_latency, i_clk, i_rst_n, i_valid && !o_stall, ##3 o_valid)
    // refused pop only happens on an empty queue, refused push on a non-empty one
    `BDEQ_ASSERT_IMPL(a_underflow_empty, i_clk, i_rst_n, o_valid && (o_status == bdeq_pkg::ST_UNDERFLOW), o_is_empty)
    `BDEQ_ASSERT_IMPL(a_overflow_nonempty, i_clk, i_rst_n, o_valid && (o_status == bdeq_pkg::ST_OVERFLOW), !o_is_empty)

endmodule

// ----- sv/bdeq_ctrl.sv -----
// Request sequencer for the bounded double-ended queue.
`timescale 1ns / 1ps

module bdeq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_stall,
    output logic              o_valid,
    output logic              o_stall,
    output bdeq_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = (r_state == S_RESP);
    assign o_cmd.load = (r_state == S_IDLE) && i_valid;
    assign o_cmd.exec = (r_state == S_EXEC);
    assign o_cmd.read = (r_state == S_READ);

endmodule

// ----- sv/bdeq_dpath.sv -----
// Ring store, pointers and result registers for the bounded double-ended queue.
`timescale 1ns / 1ps

module bdeq_dpath #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  bdeq_pkg::t_dp_cmd                          i_cmd,
    input  logic [bdeq_pkg::REQ_W-1:0]                 i_req_type,
    input  logic signed [bdeq_pkg::FIELD_W-1:0]        i_push_value,
    output logic signed [bdeq_pkg::FIELD_W-1:0]        o_front_value,
    output logic signed [bdeq_pkg::FIELD_W-1:0]        o_back_value,
    output logic [bdeq_pkg::ENTRY_COUNT_W-1:0]         o_entry_count,
    output logic                                       o_is_empty,
    output logic [bdeq_pkg::STATUS_W-1:0]              o_status
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0]          r_mem [DEPTH];

    logic [bdeq_pkg::REQ_W-1:0]     r_req;
    logic [DATA_WIDTH-1:0]          r_val;
    logic [AW-1:0]                  r_head;
    logic [AW-1:0]                  n_head;
    logic [CW-1:0]                  r_count;
    logic [CW-1:0]                  n_count;
    bdeq_pkg::t_status              r_status;
    bdeq_pkg::t_status              n_status;
    logic [DATA_WIDTH-1:0]          r_rd_front;
    logic [DATA_WIDTH-1:0]          r_rd_back;

    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [AW-1:0]                  head_inc;
    logic [AW-1:0]                  head_dec;
    logic [AW-1:0]                  tail_addr;
    logic [AW-1:0]                  back_addr;
    logic                           full;
    logic                           empty;

    // Sum of head and offset is below twice the depth: one conditional subtract.
    function automatic logic [AW-1:0] wrap(input logic [AW:0] sum);
        logic [AW:0] lim;
        lim = (AW+1)'(DEPTH);
        if (sum >= lim) begin
            wrap = AW'(sum - lim);
        end else begin
            wrap = AW'(sum);
        end
    endfunction

    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign head_inc  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign head_dec  = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign tail_addr = wrap({1'b0, r_head} + (AW+1)'(r_count));
    assign back_addr = empty ? r_head
                             : wrap({1'b0, r_head} + (AW+1)'(r_count) - (AW+1)'(1));

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = bdeq_pkg::ST_DONE;
        wr_en    = 1'b0;
        wr_addr  = tail_addr;
        case (r_req)
            bdeq_pkg::REQ_PUSH_BACK: begin
                if (full) begin
                    n_status = bdeq_pkg::ST_OVERFLOW;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            bdeq_pkg::REQ_PUSH_FRONT: begin
                if (full) begin
                    n_status = bdeq_pkg::ST_OVERFLOW;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = head_dec;
                    n_head  = head_dec;
                    n_count = r_count + CW'(1);
                end
            end
            bdeq_pkg::REQ_POP_BACK: begin
                if (empty) begin
                    n_status = bdeq_pkg::ST_UNDERFLOW;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            bdeq_pkg::REQ_POP_FRONT: begin
                if (empty) begin
                    n_status = bdeq_pkg::ST_UNDERFLOW;
                end else begin
                    n_head  = head_inc;
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                // query and unused codes leave the queue alone
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req_type;
            r_val <= DATA_WIDTH'($unsigned(i_push_value));
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[wr_addr] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_front <= r_mem[r_head];
            r_rd_back  <= r_mem[back_addr];
        end
    end

    assign o_front_value = empty ? '0 : $signed(bdeq_pkg::FIELD_W'(r_rd_front));
    assign o_back_value  = empty ? '0 : $signed(bdeq_pkg::FIELD_W'(r_rd_back));
    assign o_entry_count = bdeq_pkg::ENTRY_COUNT_W'(r_count);
    assign o_is_empty    = empty;
    assign o_status      = r_status;

endmodule
